[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by piecewise_linear_volt_db_convert_unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define PWL_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion on the block clock clk and reset rst_n.
`define PWL_ASSERT_CLK(lbl, prop, msg) \
    `PWL_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

[rtl/pwlvdb_pkg.sv]
// ---------------------------------------------------------------------------
// pwlvdb_pkg
// Constants, calibration tables and types of the piecewise-linear
// voltage / dB converter.
// ---------------------------------------------------------------------------
package pwlvdb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SEGMENTS   = 16;
    localparam int TABLE_SEGS = 16;
    localparam int SEG_USED   = (SEGMENTS < TABLE_SEGS) ? SEGMENTS : TABLE_SEGS;
    localparam int SEG_W      = $clog2(TABLE_SEGS);
    localparam int RECIP_FRAC = 24;
    localparam int SAMPLE_W   = 24;
    localparam int REF_W      = 18;
    localparam int CW         = 32;
    localparam int MW         = CW + 2;
    localparam int PW         = MW + CW;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(45023);

    typedef logic signed [CW-1:0] coef_t;
    typedef int                   dec_seg_t [TABLE_SEGS];
    typedef int                   dec_bp_t  [TABLE_SEGS+1];
    typedef coef_t                seg_tab_t [TABLE_SEGS];
    typedef coef_t                bp_tab_t  [TABLE_SEGS+1];

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result_value;
        logic                       in_range;
    } calc_res_t;

    // decimal value times 10000 to signed Q.FRAC_BITS, round half away from zero
    function automatic coef_t to_fix(input int d);
        longint unsigned m;
        longint          r;
        m = (d < 0) ? longint'(-longint'(d)) : longint'(d);
        m = ((m << FRAC_BITS) + 64'd5000) / 64'd10000;
        r = (d < 0) ? -longint'(m) : longint'(m);
        return coef_t'(r);
    endfunction

    function automatic seg_tab_t fix_seg(input dec_seg_t d);
        seg_tab_t t;
        for (int i = 0; i < TABLE_SEGS; i++)
        begin
            t[i] = to_fix(d[i]);
        end
        return t;
    endfunction

    function automatic bp_tab_t fix_bp(input dec_bp_t d);
        bp_tab_t t;
        for (int i = 0; i < TABLE_SEGS + 1; i++)
        begin
            t[i] = to_fix(d[i]);
        end
        return t;
    endfunction

    localparam dec_bp_t VOLT_BP_DEC = '{
        0, 9270, 10500, 11750, 16970, 18930, 24915, 26160, 28850,
        30075, 31230, 32470, 33710, 34960, 36150, 37375, 38460};
    localparam dec_seg_t SLOPE_DEC = '{
        -95238, -95238, -95652, -75000, -57692, -77778, -63333, -83333,
        -65385, -75555, -78164, -84284, -81759, -87927, -79222, -94167};
    localparam dec_seg_t ICPT_DEC = '{
        65429, 66814, 68370, 44900, 16438, 53033, 15770, 66900,
        16054, 48079, 56471, 76412, 68137, 89675, 58061, 113685};
    localparam dec_bp_t DB_BP_DEC = '{
        0, -21700, -32500, -43100, -81350, -93950, -141400, -151050, -172550,
        -181850, -187850, -197500, -207650, -217750, -228300, -238300, -248400};

    localparam bp_tab_t  VOLT_BP = fix_bp(VOLT_BP_DEC);
    localparam seg_tab_t SLOPE   = fix_seg(SLOPE_DEC);
    localparam seg_tab_t ICPT    = fix_seg(ICPT_DEC);
    localparam bp_tab_t  DB_BP   = fix_bp(DB_BP_DEC);

    // slope reciprocals, signed Q.RECIP_FRAC
    localparam seg_tab_t RECIP = '{
        -1761609, -1761609, -1753985, -2236962, -2908066, -2157064, -2649048, -2013274,
        -2565912, -2220530, -2146412, -1990558, -2052033, -1908085, -2117747, -1781645};

    localparam coef_t REF_DROP = to_fix(6870);

endpackage

[rtl/piecewise_linear_volt_db_convert_unit.sv]
// ---------------------------------------------------------------------------
// piecewise_linear_volt_db_convert_unit
// Voltage to dB and dB to voltage conversion through a 16-segment
// piecewise-linear calibration, one item per cycle while the output is taken.
//
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------
// input    | in_valid / in_ready    | kind, sample_value
// output   | out_valid / out_ready  | result_value, in_range
// config   | cfg_wr_en              | cfg_wr_data (reference_voltage)
//
// An item passes from acceptance through the input register, then through
// compare, table lookup and one multiply-add into the result register.
// A new item is accepted every cycle while the output is taken.
// A stalled output holds both stages; in_ready drops only when both are full.
// Reset empties both stages and loads reference_voltage with 45023.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module piecewise_linear_volt_db_convert_unit
    import pwlvdb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] result_value,
    output logic                       in_range,
    input  logic                       cfg_wr_en,
    input  logic        [REF_W-1:0]    cfg_wr_data
);

    logic                       s1_valid_reg;
    logic                       s1_kind_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       out_valid_reg;
    calc_res_t                  out_res_reg;
    logic        [REF_W-1:0]    ref_reg;
    logic                       advance;
    logic                       s1_valid_next;
    calc_res_t                  calc_res;

    assign advance       = !out_valid_reg || out_ready;
    assign in_ready      = !s1_valid_reg || advance;
    assign s1_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    pwlvdb_calc u_calc
    (
        .kind              (s1_kind_reg),
        .sample_value      (s1_sample_reg),
        .reference_voltage (ref_reg),
        .res               (calc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ref_reg       <= REF_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (cfg_wr_en)
            begin
                ref_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg   <= kind;
            s1_sample_reg <= sample_value;
        end
        if (advance && s1_valid_reg)
        begin
            out_res_reg <= calc_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_res_reg.result_value;
    assign in_range     = out_res_reg.in_range;

    `PWL_ASSERT_CLK(a_ready_when_out_free, !out_valid_reg |-> in_ready,
        "in_ready low with empty output stage")
    `PWL_ASSERT_CLK(a_accept_fills_s1, (in_valid && in_ready) |=> s1_valid_reg,
        "accepted item lost before input register")
    `PWL_ASSERT_CLK(a_zero_db_in_range,
        (s1_valid_reg && advance && s1_kind_reg && (s1_sample_reg == '0)) |=>
        (out_valid && in_range), "zero dB item not reported in range")
    `PWL_ASSERT_CLK(a_miss_gives_zero, (out_valid && !in_range) |-> (result_value == '0),
        "out-of-range item with nonzero result")

endmodule

[rtl/pwlvdb_calc.sv]
// ---------------------------------------------------------------------------
// pwlvdb_calc
// Segment search, table lookup, multiply-add, rounding and saturation for
// one conversion item.
// ---------------------------------------------------------------------------
module pwlvdb_calc
    import pwlvdb_pkg::*;
(
    input  logic                       kind,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic        [REF_W-1:0]    reference_voltage,
    output calc_res_t                  res
);

    localparam int RES_MAX = 2 ** (SAMPLE_W - 1) - 1;
    localparam int RES_MIN = -(2 ** (SAMPLE_W - 1));
    localparam logic signed [PW-1:0] HALF_F  = PW'(1 << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0] HALF_R  = PW'(1 << (RECIP_FRAC - 1));
    localparam logic signed [PW-1:0] SAT_HI  = PW'(RES_MAX);
    localparam logic signed [PW-1:0] SAT_LO  = PW'(RES_MIN);

    function automatic logic signed [MW-1:0] ext(input coef_t c);
        return {{(MW-CW){c[CW-1]}}, c};
    endfunction

    logic signed [MW-1:0] s_ext;
    logic signed [MW-1:0] x_ext;
    logic signed [MW-1:0] offset;
    logic signed [MW-1:0] diff_v;
    logic signed [MW-1:0] diff_d;
    logic [TABLE_SEGS-1:0] v_hit;
    logic [TABLE_SEGS-1:0] d_hit;
    logic [SEG_W-1:0]      v_seg;
    logic [SEG_W-1:0]      d_seg;
    logic [SEG_W-1:0]      seg;
    logic                  hit;
    coef_t                 slope_c;
    coef_t                 icpt_c;
    coef_t                 recip_c;
    logic signed [MW-1:0]  op_a;
    coef_t                 op_b;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  rnd_f;
    logic signed [PW-1:0]  rnd_r;
    logic signed [PW-1:0]  sum;
    logic signed [PW-1:0]  sat;

    assign s_ext  = {{(MW-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
    assign x_ext  = -s_ext;
    assign offset = $signed({{(MW-REF_W){1'b0}}, reference_voltage}) - ext(REF_DROP);

    always_comb
    begin
        v_hit = '0;
        d_hit = '0;
        for (int i = 0; i < SEG_USED; i++)
        begin
            v_hit[i] = (s_ext > ext(VOLT_BP[i])) && (s_ext <= ext(VOLT_BP[i+1]));
            d_hit[i] = (x_ext < ext(DB_BP[i])) && (x_ext >= ext(DB_BP[i+1]));
        end
    end

    // lowest matching segment wins
    always_comb
    begin
        v_seg = '0;
        d_seg = '0;
        for (int i = TABLE_SEGS - 1; i >= 0; i--)
        begin
            if (v_hit[i])
            begin
                v_seg = SEG_W'(i);
            end
            if (d_hit[i])
            begin
                d_seg = SEG_W'(i);
            end
        end
    end

    always_comb
    begin
        if (kind)
        begin
            hit = (x_ext == '0) || (|d_hit);
            seg = (x_ext == '0) ? '0 : d_seg;
        end
        else
        begin
            hit = |v_hit;
            seg = v_seg;
        end
    end

    assign slope_c = SLOPE[seg];
    assign icpt_c  = ICPT[seg];
    assign recip_c = RECIP[seg];

    assign diff_v = s_ext - offset;
    assign diff_d = x_ext - ext(icpt_c);

    assign op_a = kind ? diff_d : diff_v;
    assign op_b = kind ? recip_c : slope_c;
    assign prod = PW'(op_a) * PW'(op_b);

    assign rnd_f = (prod + HALF_F) >>> FRAC_BITS;
    assign rnd_r = (prod + HALF_R) >>> RECIP_FRAC;

    always_comb
    begin
        if (kind)
        begin
            sum = rnd_r;
        end
        else
        begin
            sum = rnd_f + PW'(icpt_c);
        end
        if (!hit)
        begin
            sat = '0;
        end
        else if (sum > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (sum < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = sum;
        end
    end

    assign res.result_value = sat[SAMPLE_W-1:0];
    assign res.in_range     = hit;

endmodule
